// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define HTBA_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("htba assertion failed");

// a signal holds while its beat is stalled
`define HTBA_HOLD(name, stall, sig) \
    `HTBA_ASSERT(name, (stall) |=> $stable(sig))

`endif

// ===== hw/rtl/htba_pkg.sv =====
// types and constants of the handle table allocator
package htba_pkg;

    localparam int OP_W       = 3;
    localparam int HANDLE_W   = 6;
    localparam int DESC_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;
    localparam int COUNT_W    = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DESC_W - SLOT_OUT_W;

    localparam logic [OP_W-1:0] OP_OPEN   = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_OPEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASE  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [DESC_W-1:0]     desc;
        logic                  last;
    } result_t;

endpackage

// ===== hw/rtl/handle_table_bitmap_alloc_core.sv =====
// handle table: bitmap slot allocator with descriptor ram and release walk
//
// input channel s_*: one beat per request, operation in s_tuser, handle and
// host descriptor in s_tdata. output channel m_*: result beats, status in
// m_tuser, slot and descriptor in m_tdata, m_tlast on the final result of a
// request. operations 5 to 7 are dropped without a result.
// one request is worked on at a time; s_tready is high only while idle.
// open, add_user, a drop_user that leaves the count above zero and failed
// close/lookup pass from accept through the result state to the output; a good
// close or lookup first reads the descriptor ram, a walk with no open slot
// passes through the walk state first, and a release walk repeats find lowest
// slot, ram read and result for each open slot. s_tready returns as a
// request's final result loads. results sit in a single output register; a
// new result waits in res_reg until m_tready takes the previous one, so a
// stalled receiver holds the block in its result state and s_tready stays low.
// after reset the low RESERVED_SLOTS slots are marked in use, the user count
// is one and the output is empty; the descriptor ram is not cleared since a
// slot is only read after open has written it.
module handle_table_bitmap_alloc_core
    import htba_pkg::*;
#(
    parameter int SLOT_COUNT     = 32,
    parameter int RESERVED_SLOTS = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // handle, host_descriptor, zero pad
    input  logic [OP_W-1:0]        s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // slot, descriptor_out, zero pad
    output logic [STATUS_W-1:0]    m_tuser,   // status
    output logic                   m_tlast
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CMP_W = HANDLE_W + 1;
    localparam logic [CMP_W-1:0] SLOT_LIMIT = CMP_W'(SLOT_COUNT);
    localparam logic [CMP_W-1:0] RESV_LIMIT = CMP_W'(RESERVED_SLOTS);

    function automatic logic [SLOT_COUNT-1:0] resv_mask_f();
        logic [SLOT_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            m[i] = (i < RESERVED_SLOTS);
        end
        return m;
    endfunction

    localparam logic [SLOT_COUNT-1:0] RESV_MASK = resv_mask_f();

    state_t                 state_reg,  state_next;
    logic [SLOT_COUNT-1:0]  bitmap_reg, bitmap_next;
    logic [COUNT_W-1:0]     count_reg,  count_next;
    result_t                res_reg,    res_next;
    result_t                out_reg,    out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [HANDLE_W-1:0]    handle;
    logic [DESC_W-1:0]      host_desc;
    logic [OP_W-1:0]        op;
    logic                   accept;
    logic                   handle_open;
    logic [SLOT_COUNT-1:0]  walk_mask;
    logic [SLOT_COUNT-1:0]  walk_rest;
    logic [SLOT_COUNT-1:0]  pe_vec;
    logic                   pe_found;
    logic [IDX_W-1:0]       pe_idx;
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [DESC_W-1:0]      ram_rd_data;
    logic                   out_free;

    assign handle    = s_tdata[HANDLE_W-1:0];
    assign host_desc = s_tdata[HANDLE_W +: DESC_W];
    assign op        = s_tuser;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign handle_open = (CMP_W'(handle) >= RESV_LIMIT) && (CMP_W'(handle) < SLOT_LIMIT)
                         && bitmap_reg[handle[IDX_W-1:0]];

    assign walk_mask = bitmap_reg & ~RESV_MASK;
    assign pe_vec    = (state_reg == S_WALK) ? walk_mask : ~bitmap_reg;

    always_comb
    begin
        walk_rest         = walk_mask;
        walk_rest[pe_idx] = 1'b0;
    end

    htba_lowest #(
        .WIDTH (SLOT_COUNT)
    ) u_lowest (
        .vec   (pe_vec),
        .found (pe_found),
        .idx   (pe_idx)
    );

    assign ram_wr_en   = accept && (op == OP_OPEN) && pe_found;
    assign ram_rd_addr = (state_reg == S_WALK) ? pe_idx : handle[IDX_W-1:0];

    htba_ram #(
        .WIDTH (DESC_W),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pe_idx),
        .wr_data (host_desc),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        bitmap_next    = bitmap_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: ST_OK, slot: '0, desc: '0, last: 1'b1};
                    state_next = S_RESP;
                    case (op)
                        OP_OPEN:
                        begin
                            if (pe_found)
                            begin
                                bitmap_next[pe_idx] = 1'b1;
                                res_next.slot = SLOT_OUT_W'(pe_idx);
                                res_next.desc = host_desc;
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        OP_CLOSE, OP_LOOKUP:
                        begin
                            if (handle_open)
                            begin
                                if (op == OP_CLOSE)
                                begin
                                    bitmap_next[handle[IDX_W-1:0]] = 1'b0;
                                end
                                res_next.slot = SLOT_OUT_W'(handle);
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = ST_NOT_OPEN;
                            end
                        end
                        OP_ADD:
                        begin
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_DROP:
                        begin
                            if (count_reg > COUNT_W'(1))
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                count_next = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (pe_found)
                begin
                    bitmap_next[pe_idx] = 1'b0;
                    res_next = '{status: ST_RELEASE, slot: SLOT_OUT_W'(pe_idx),
                                 desc: '0, last: (walk_rest == '0)};
                    state_next = S_READ;
                end
                else
                begin
                    res_next = '{status: ST_OK, slot: '0, desc: '0, last: 1'b1};
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                res_next.desc = ram_rd_data;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    if ((res_reg.status == ST_RELEASE) && !res_reg.last)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bitmap_reg    <= RESV_MASK;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bitmap_reg    <= bitmap_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.desc, out_reg.slot};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

// ===== hw/rtl/htba_ram.sv =====
// generic single-write, single-read ram with registered read data
module htba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/htba_lowest.sv =====
// lowest set bit finder over the slot bitmap
module htba_lowest #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] idx
);

    localparam int IDX_W = $clog2(WIDTH);

    always_comb
    begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign found = |vec;

endmodule

// ===== hw/rtl/htba_checker.sv =====
// port checker for the handle table allocator, bound to the top level
`include "assert_macros.svh"

module htba_checker
    import htba_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   m_tlast
);

    `HTBA_ASSERT(a_valid_holds, (m_tvalid && !m_tready) |=> m_tvalid)
    `HTBA_HOLD(a_beat_holds, m_tvalid && !m_tready, {m_tdata, m_tuser, m_tlast})
    // failures carry no slot and no descriptor
    `HTBA_ASSERT(a_fail_zero, (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NOT_OPEN)) |-> (m_tdata == '0))
    // only release beats may continue a run
    `HTBA_ASSERT(a_single_last, (m_tvalid && (m_tuser != ST_RELEASE)) |-> m_tlast)

endmodule

bind handle_table_bitmap_alloc_core htba_checker u_htba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
